FILE: hdl/hnlscan_pkg.sv
// ----------------------------------------------------------------------------
// hnlscan_pkg - shared constants for the number literal scanner
// Character codes, scan modes, result kinds, run bases and the default count width.
// ----------------------------------------------------------------------------
package hnlscan_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  localparam int LEN_OUT_W       = 16;

  // scan modes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_ZERO = 3'd1;
  localparam logic [2:0] MODE_DEC  = 3'd2;
  localparam logic [2:0] MODE_APOS = 3'd3;
  localparam logic [2:0] MODE_RUN  = 3'd4;

  // result kinds
  localparam logic [2:0] KIND_UNKNOWN = 3'd0;
  localparam logic [2:0] KIND_DEC     = 3'd1;
  localparam logic [2:0] KIND_BIN     = 3'd2;
  localparam logic [2:0] KIND_OCT     = 3'd3;
  localparam logic [2:0] KIND_HEX     = 3'd4;

  // run bases
  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_BIN = 2'd1;
  localparam logic [1:0] BASE_OCT = 2'd2;
  localparam logic [1:0] BASE_HEX = 2'd3;

  // characters
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_7     = 8'h37;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_UPA   = 8'h41;
  localparam logic [7:0] CH_UPF   = 8'h46;
  localparam logic [7:0] CH_UPZ   = 8'h5A;
  localparam logic [7:0] CH_LOA   = 8'h61;
  localparam logic [7:0] CH_LOF   = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_Z     = 8'h7A;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_APOS  = 8'h27;
  localparam logic [7:0] CASE_OFS = 8'h20;

endpackage

FILE: hdl/hdl_number_literal_scanner.sv
// ----------------------------------------------------------------------------
// hdl_number_literal_scanner - number literal recogniser for an HDL lexer
//
// Input channel (in_valid / in_stall): one character per transfer with
// start_scan and buffer_end flags. A scan accepts plain decimal, 0x / 0b
// runs and sized <n>'<radix> runs, accepting underscores and noting Z, X and
// U markers in non-decimal runs.
// Output channel (out_valid / out_stall): one result (kind, length, flags)
// when the scan meets a character it does not take, or the buffer ends. The
// ending character is not consumed.
// Timing: one character per cycle, sustained while in_stall is low. A result is
// registered on the output in the cycle after the transfer that ends the scan.
// The scan state updates in a single pass of decode logic per character.
// While the receiver stalls, the output register holds its result and the
// input is stalled only if that register is full; a result taken in the
// same cycle frees it for the next one.
// Reset clears the scan to idle and empties the output register.
// ----------------------------------------------------------------------------
module hdl_number_literal_scanner #(
  parameter int LENGTH_BITS = hnlscan_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  ch,
  input  logic        start_scan,
  input  logic        buffer_end,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  kind,
  output logic [15:0] length,
  output logic        has_z,
  output logic        has_x,
  output logic        has_u
);

  logic [2:0]             scan_mode, scan_mode_next;
  logic [LENGTH_BITS-1:0] count, count_next, count_base;
  logic [1:0]             run_base, run_base_next;
  logic [2:0]             flags, flags_next;
  logic [2:0]             result_kind, result_kind_next;

  logic                   accept;
  logic                   emit;
  logic [2:0]             emit_kind;
  logic [2:0]             emit_flags;
  logic [1:0]             inc;
  logic [LENGTH_BITS:0]   sum;
  logic [LENGTH_BITS+15:0] count_ext;
  logic [15:0]            emit_len;

  logic [7:0] lc;
  logic       is_dec, is_hex, is_us, is_apos;
  logic       run_ok;

  assign in_stall = out_valid & out_stall;
  assign accept   = in_valid & ~in_stall;

  // character classes
  always_comb begin
    lc = ((ch >= hnlscan_pkg::CH_UPA) && (ch <= hnlscan_pkg::CH_UPZ)) ?
         ch + hnlscan_pkg::CASE_OFS : ch;
    is_dec  = (ch >= hnlscan_pkg::CH_0) && (ch <= hnlscan_pkg::CH_9);
    is_hex  = is_dec ||
              ((ch >= hnlscan_pkg::CH_LOA) && (ch <= hnlscan_pkg::CH_LOF)) ||
              ((ch >= hnlscan_pkg::CH_UPA) && (ch <= hnlscan_pkg::CH_UPF));
    is_us   = (ch == hnlscan_pkg::CH_USCORE);
    is_apos = (ch == hnlscan_pkg::CH_APOS);
  end

  always_comb begin
    scan_mode_next   = scan_mode;
    run_base_next    = run_base;
    flags_next       = flags;
    result_kind_next = result_kind;
    count_base       = count;
    inc              = 2'd0;
    emit             = 1'b0;
    emit_kind        = hnlscan_pkg::KIND_DEC;
    emit_flags       = 3'b000;
    run_ok           = 1'b0;

    if (start_scan) begin
      count_base       = '0;
      run_base_next    = hnlscan_pkg::BASE_DEC;
      flags_next       = 3'b000;
      result_kind_next = hnlscan_pkg::KIND_UNKNOWN;
      if (buffer_end || !is_dec) begin
        emit      = 1'b1;
        emit_kind = hnlscan_pkg::KIND_UNKNOWN;
      end else begin
        scan_mode_next = (ch == hnlscan_pkg::CH_0) ? hnlscan_pkg::MODE_ZERO
                                                   : hnlscan_pkg::MODE_DEC;
        inc = 2'd1;
      end
    end else if (scan_mode == hnlscan_pkg::MODE_IDLE) begin
      // nothing to do until a scan starts
    end else if (buffer_end) begin
      emit = 1'b1;
      if (scan_mode == hnlscan_pkg::MODE_RUN) begin
        emit_kind  = result_kind;
        emit_flags = flags;
      end
    end else begin
      case (scan_mode)
        hnlscan_pkg::MODE_ZERO, hnlscan_pkg::MODE_DEC: begin
          if ((scan_mode == hnlscan_pkg::MODE_ZERO) &&
              ((lc == hnlscan_pkg::CH_X) || (lc == hnlscan_pkg::CH_B))) begin
            scan_mode_next = hnlscan_pkg::MODE_RUN;
            inc            = 2'd1;
            if (lc == hnlscan_pkg::CH_X) begin
              run_base_next    = hnlscan_pkg::BASE_HEX;
              result_kind_next = hnlscan_pkg::KIND_HEX;
            end else begin
              run_base_next    = hnlscan_pkg::BASE_BIN;
              result_kind_next = hnlscan_pkg::KIND_BIN;
            end
          end else if (is_dec || is_us) begin
            scan_mode_next = hnlscan_pkg::MODE_DEC;
            inc            = 2'd1;
          end else if (is_apos) begin
            scan_mode_next = hnlscan_pkg::MODE_APOS;
          end else begin
            emit = 1'b1;
          end
        end
        hnlscan_pkg::MODE_APOS: begin
          // apostrophe and radix are counted together once the radix is seen
          if (lc == hnlscan_pkg::CH_B || lc == hnlscan_pkg::CH_O ||
              lc == hnlscan_pkg::CH_D || lc == hnlscan_pkg::CH_H) begin
            scan_mode_next = hnlscan_pkg::MODE_RUN;
            inc            = 2'd2;
            if (lc == hnlscan_pkg::CH_B) begin
              run_base_next    = hnlscan_pkg::BASE_BIN;
              result_kind_next = hnlscan_pkg::KIND_BIN;
            end else if (lc == hnlscan_pkg::CH_O) begin
              run_base_next    = hnlscan_pkg::BASE_OCT;
              result_kind_next = hnlscan_pkg::KIND_OCT;
            end else if (lc == hnlscan_pkg::CH_H) begin
              run_base_next    = hnlscan_pkg::BASE_HEX;
              result_kind_next = hnlscan_pkg::KIND_HEX;
            end else begin
              run_base_next    = hnlscan_pkg::BASE_DEC;
              result_kind_next = hnlscan_pkg::KIND_DEC;
            end
          end else begin
            emit = 1'b1;
          end
        end
        hnlscan_pkg::MODE_RUN: begin
          if (run_base == hnlscan_pkg::BASE_DEC) begin
            run_ok = is_dec || is_us;
          end else if (is_us) begin
            run_ok = 1'b1;
          end else if (lc == hnlscan_pkg::CH_Z) begin
            run_ok     = 1'b1;
            flags_next = flags | 3'b001;
          end else if (lc == hnlscan_pkg::CH_X) begin
            run_ok     = 1'b1;
            flags_next = flags | 3'b010;
          end else if (lc == hnlscan_pkg::CH_U) begin
            run_ok     = 1'b1;
            flags_next = flags | 3'b100;
          end else begin
            case (run_base)
              hnlscan_pkg::BASE_BIN: run_ok = (ch == hnlscan_pkg::CH_0) ||
                                              (ch == hnlscan_pkg::CH_1);
              hnlscan_pkg::BASE_OCT: run_ok = (ch >= hnlscan_pkg::CH_0) &&
                                              (ch <= hnlscan_pkg::CH_7);
              hnlscan_pkg::BASE_HEX: run_ok = is_hex;
              default:               run_ok = 1'b0;
            endcase
          end
          if (run_ok) begin
            inc = 2'd1;
          end else begin
            emit       = 1'b1;
            emit_kind  = result_kind;
            emit_flags = flags;
          end
        end
        default: begin
          emit = 1'b1;
        end
      endcase
    end

    if (emit) begin
      scan_mode_next = hnlscan_pkg::MODE_IDLE;
    end
  end

  // saturating count
  always_comb begin
    sum = {1'b0, count_base} + {{(LENGTH_BITS-1){1'b0}}, inc};
    count_next = sum[LENGTH_BITS] ? {LENGTH_BITS{1'b1}} : sum[LENGTH_BITS-1:0];
    count_ext  = {16'd0, count_base};
    emit_len   = (count_ext > {{LENGTH_BITS{1'b0}}, 16'hFFFF}) ? 16'hFFFF
                                                               : count_ext[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_mode   <= hnlscan_pkg::MODE_IDLE;
      count       <= '0;
      run_base    <= hnlscan_pkg::BASE_DEC;
      flags       <= 3'b000;
      result_kind <= hnlscan_pkg::KIND_UNKNOWN;
    end else if (accept) begin
      scan_mode   <= scan_mode_next;
      count       <= count_next;
      run_base    <= run_base_next;
      flags       <= flags_next;
      result_kind <= result_kind_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept && emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && emit) begin
      kind   <= emit_kind;
      length <= emit_len;
      has_z  <= emit_flags[0];
      has_x  <= emit_flags[1];
      has_u  <= emit_flags[2];
    end
  end

endmodule
